### rtl/ppf_pkg.sv
// Package for the pulse profile folder: payload types, command type and constants.
package ppf_pkg;

    // Widest bin number the design supports (4096 bins)
    localparam int CMD_BIN_W   = 12;
    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    // Depth of the result buffer in the back
    localparam int OUT_DEPTH   = 4;

    // Saturation limits of a 24-bit bin, 8 fraction bits
    localparam logic signed [26:0] BIN_MAX = 27'sd8388607;
    localparam logic signed [26:0] BIN_MIN = -27'sd8388608;

    typedef logic [CMD_BIN_W-1:0] cmd_bin_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FOLD_ENABLE = 2'd0,
        CFG_PHASE_STEP  = 2'd1,
        CFG_ALPHA_Q16   = 2'd2
    } cfg_index_t;

    // Request types
    typedef enum logic {
        REQ_FOLD = 1'b0,
        REQ_READ = 1'b1
    } req_kind_t;

    // Incoming request
    typedef struct packed {
        logic               req_type;
        logic signed [15:0] sample;
        logic [8:0]         read_bin;
    } ppf_req_t;

    // Outgoing result
    typedef struct packed {
        logic [8:0]         bin_index;
        logic signed [23:0] bin_value;
        logic               updated;
    } ppf_res_t;

    // Classified command from front to back
    typedef struct packed {
        logic               write;
        cmd_bin_t           bin;
        logic signed [15:0] sample;
    } ppf_cmd_t;

endpackage

### rtl/ppf_front.sv
// Front end: configuration registers, phase accumulator and request classification.
module ppf_front #(
    parameter int BINS = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  ppf_pkg::ppf_req_t req_data,
    input  logic              queue_full,
    input  logic              clear_busy,
    output logic              push,
    output ppf_pkg::ppf_cmd_t cmd,
    output logic [15:0]       alpha_q16
);

    localparam int BIN_W = $clog2(BINS);

    logic        fold_enable_reg, fold_enable_next;
    logic [31:0] phase_step_reg, phase_step_next;
    logic [15:0] alpha_reg, alpha_next;
    logic [31:0] phase_reg, phase_next;

    logic [BIN_W-1:0]         phase_bin;
    ppf_pkg::cmd_bin_t        read_ext;

    // Handshake: hold off while the queue is full or the profile is clearing
    assign req_stall = queue_full || clear_busy;
    assign push      = req_valid && !req_stall;
    assign alpha_q16 = alpha_reg;

    // Bin picked by the top bits of the phase; read bin wraps modulo BINS
    assign phase_bin = phase_reg[31 -: BIN_W];
    assign read_ext  = ppf_pkg::cmd_bin_t'(req_data.read_bin);

    // Classify the request
    always_comb
    begin
        cmd.sample = req_data.sample;
        if (req_data.req_type == ppf_pkg::REQ_READ)
        begin
            cmd.write = 1'b0;
            cmd.bin   = ppf_pkg::cmd_bin_t'(read_ext[BIN_W-1:0]);
        end
        else
        begin
            cmd.write = fold_enable_reg;
            cmd.bin   = ppf_pkg::cmd_bin_t'(phase_bin);
        end
    end

    // Configuration writes
    always_comb
    begin
        fold_enable_next = fold_enable_reg;
        phase_step_next  = phase_step_reg;
        alpha_next       = alpha_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ppf_pkg::CFG_FOLD_ENABLE: fold_enable_next = cfg_data[0];
                ppf_pkg::CFG_PHASE_STEP:  phase_step_next  = cfg_data;
                ppf_pkg::CFG_ALPHA_Q16:   alpha_next       = cfg_data[15:0];
                default:                  ;
            endcase
        end
    end

    // Phase advances once per folded sample
    always_comb
    begin
        phase_next = phase_reg;
        if (push && req_data.req_type == ppf_pkg::REQ_FOLD && fold_enable_reg)
        begin
            phase_next = phase_reg + phase_step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_enable_reg <= 1'b0;
            phase_step_reg  <= '0;
            alpha_reg       <= 16'hFFFF;
            phase_reg       <= '0;
        end
        else
        begin
            fold_enable_reg <= fold_enable_next;
            phase_step_reg  <= phase_step_next;
            alpha_reg       <= alpha_next;
            phase_reg       <= phase_next;
        end
    end

endmodule

### rtl/ppf_queue.sv
// Short command queue between front and back.
module ppf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ppf_pkg::ppf_cmd_t cmd_in,
    input  logic              pop,
    output ppf_pkg::ppf_cmd_t cmd_out,
    output logic              not_empty,
    output logic              full
);

    localparam int PTR_W = $clog2(ppf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ppf_pkg::QUEUE_DEPTH + 1);

    ppf_pkg::ppf_cmd_t entries_reg [ppf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(ppf_pkg::QUEUE_DEPTH));
    assign cmd_out   = entries_reg[head_reg];

    // Pointer and fill count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(ppf_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(ppf_pkg::QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[tail_reg] <= cmd_in;
        end
    end

endmodule

### rtl/ppf_back.sv
// Back end: profile memory, clearing pass, bin read-modify-write and result buffer.
module ppf_back #(
    parameter int BINS = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       alpha_q16,
    input  ppf_pkg::ppf_cmd_t cmd,
    input  logic              cmd_valid,
    output logic              pop,
    output logic              clear_busy,
    output logic              res_valid,
    input  logic              res_stall,
    output ppf_pkg::ppf_res_t res_data
);

    localparam int BIN_W  = $clog2(BINS);
    localparam int OPTR_W = $clog2(ppf_pkg::OUT_DEPTH);
    localparam int OCNT_W = $clog2(ppf_pkg::OUT_DEPTH + 1);

    // Profile memory
    logic [23:0]              mem [BINS];
    logic signed [23:0]       rdata_reg;
    logic                     mem_we;
    logic [BIN_W-1:0]         mem_waddr;
    logic [23:0]              mem_wdata;

    // Clearing pass
    logic                     clear_busy_reg, clear_busy_next;
    logic [BIN_W-1:0]         clear_idx_reg, clear_idx_next;

    // Update stage
    logic                     s2_valid_reg, s2_valid_next;
    ppf_pkg::ppf_cmd_t        s2_cmd_reg;
    logic [BIN_W-1:0]         s2_bin;

    // Last write, for a back-to-back update of the same bin
    logic                     wb_valid_reg, wb_valid_next;
    logic [BIN_W-1:0]         wb_bin_reg;
    logic signed [23:0]       wb_value_reg;

    // Result buffer
    ppf_pkg::ppf_res_t        out_reg [ppf_pkg::OUT_DEPTH];
    logic [OPTR_W-1:0]        out_head_reg, out_head_next;
    logic [OPTR_W-1:0]        out_tail_reg, out_tail_next;
    logic [OCNT_W-1:0]        out_count_reg, out_count_next;
    logic                     out_push;
    logic                     out_pop;
    ppf_pkg::ppf_res_t        res_new;

    // Arithmetic
    logic signed [23:0]       old_value;
    logic signed [23:0]       sample_scaled;
    logic signed [24:0]       diff;
    logic signed [16:0]       alpha_s;
    logic signed [41:0]       prod;
    logic signed [41:0]       prod_rnd;
    logic signed [25:0]       incr;
    logic signed [26:0]       sum;
    logic signed [23:0]       new_value;
    logic                     credit_ok;

    assign clear_busy = clear_busy_reg;
    assign s2_bin     = s2_cmd_reg.bin[BIN_W-1:0];

    // Issue a command only when the result buffer has room for it
    assign credit_ok = (32'(out_count_reg) + 32'(s2_valid_reg)) < ppf_pkg::OUT_DEPTH;
    assign pop       = cmd_valid && !clear_busy_reg && credit_ok;

    // Old bin value, bypassing the write made in the previous cycle
    assign old_value = (wb_valid_reg && wb_bin_reg == s2_bin) ? wb_value_reg : rdata_reg;

    // Exponential average: old + round(alpha * (sample*256 - old) / 2^16)
    always_comb
    begin
        sample_scaled = {s2_cmd_reg.sample, 8'h00};
        diff          = 25'(sample_scaled) - 25'(old_value);
        alpha_s       = signed'({1'b0, alpha_q16});
        prod          = alpha_s * diff;
        prod_rnd      = prod + 42'sd32768;
        incr          = signed'(prod_rnd[41:16]);
        sum           = 27'(old_value) + 27'(incr);
        if (sum > ppf_pkg::BIN_MAX)
        begin
            new_value = ppf_pkg::BIN_MAX[23:0];
        end
        else if (sum < ppf_pkg::BIN_MIN)
        begin
            new_value = ppf_pkg::BIN_MIN[23:0];
        end
        else
        begin
            new_value = sum[23:0];
        end
    end

    // Memory write: clearing pass or a folded sample
    always_comb
    begin
        if (clear_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s2_valid_reg && s2_cmd_reg.write;
            mem_waddr = s2_bin;
            mem_wdata = new_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rdata_reg <= mem[cmd.bin[BIN_W-1:0]];
        end
    end

    // Clearing pass control
    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_idx_next  = clear_idx_reg;
        if (clear_busy_reg)
        begin
            clear_idx_next  = clear_idx_reg + 1'b1;
            clear_busy_next = (clear_idx_reg != BIN_W'(BINS - 1));
        end
    end

    // Stage and bypass control
    assign s2_valid_next = pop;
    assign wb_valid_next = s2_valid_reg && s2_cmd_reg.write;

    // Result of the update stage
    always_comb
    begin
        res_new.bin_index = s2_cmd_reg.bin[8:0];
        res_new.bin_value = s2_cmd_reg.write ? new_value : old_value;
        res_new.updated   = s2_cmd_reg.write;
    end

    // Result buffer control
    assign out_push  = s2_valid_reg;
    assign res_valid = (out_count_reg != '0);
    assign out_pop   = res_valid && !res_stall;
    assign res_data  = out_reg[out_head_reg];

    always_comb
    begin
        out_head_next  = out_head_reg;
        out_tail_next  = out_tail_reg;
        out_count_next = out_count_reg;
        if (out_push)
        begin
            out_tail_next = (out_tail_reg == OPTR_W'(ppf_pkg::OUT_DEPTH - 1)) ? '0
                          : out_tail_reg + 1'b1;
        end
        if (out_pop)
        begin
            out_head_next = (out_head_reg == OPTR_W'(ppf_pkg::OUT_DEPTH - 1)) ? '0
                          : out_head_reg + 1'b1;
        end
        case ({out_push, out_pop})
            2'b10:   out_count_next = out_count_reg + 1'b1;
            2'b01:   out_count_next = out_count_reg - 1'b1;
            default: out_count_next = out_count_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_idx_reg  <= '0;
            s2_valid_reg   <= 1'b0;
            wb_valid_reg   <= 1'b0;
            out_head_reg   <= '0;
            out_tail_reg   <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_idx_reg  <= clear_idx_next;
            s2_valid_reg   <= s2_valid_next;
            wb_valid_reg   <= wb_valid_next;
            out_head_reg   <= out_head_next;
            out_tail_reg   <= out_tail_next;
            out_count_reg  <= out_count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_cmd_reg <= cmd;
        end
        wb_bin_reg   <= s2_bin;
        wb_value_reg <= new_value;
        if (out_push)
        begin
            out_reg[out_tail_reg] <= res_new;
        end
    end

    // No command is issued while the profile is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) clear_busy_reg |-> !pop)
        else $error("command issued during clearing pass");

    // An update always finds room in the result buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (32'(out_count_reg) < ppf_pkg::OUT_DEPTH))
        else $error("result buffer overflow");

    // The bypass register follows exactly the write of the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_cmd_reg.write) |=> (wb_valid_reg && wb_bin_reg == $past(s2_bin)))
        else $error("bypass register lost a write");

endmodule

### rtl/pulse_profile_folder.sv
// Pulse profile folder: epoch folding of a detector power stream into a binned profile.
// Takes one request per clock while req_stall is low, fold or read, sustained, including folds
// that hit the same bin in consecutive cycles; a result goes from the command queue through
// the update stage into the result buffer; the path is set by the bin read-modify-write of
// the update stage (memory read, one 17x25 multiply, rounding add, saturation, write, with a
// one-deep bypass). The front keeps the phase accumulator and picks the bin (top log2(BINS)
// bits of the phase for a fold, read_bin modulo BINS for a read); a two-entry command queue
// feeds the back, which owns the profile memory and a four-entry result buffer, so a stalled
// result does not stop new requests until both fill. After reset the profile memory is
// zeroed by a clearing pass over every bin, during which req_stall is high; configuration
// writes are taken at any time.
module pulse_profile_folder #(
    parameter int BINS = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  ppf_pkg::ppf_req_t req_data,
    output logic              res_valid,
    input  logic              res_stall,
    output ppf_pkg::ppf_res_t res_data
);

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_not_empty;
    logic              clear_busy;
    logic [15:0]       alpha_q16;
    ppf_pkg::ppf_cmd_t front_cmd;
    ppf_pkg::ppf_cmd_t back_cmd;

    // Front: configuration, phase and classification
    ppf_front #(
        .BINS (BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .queue_full (queue_full),
        .clear_busy (clear_busy),
        .push       (push),
        .cmd        (front_cmd),
        .alpha_q16  (alpha_q16)
    );

    // Command queue
    ppf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd_in    (front_cmd),
        .pop       (pop),
        .cmd_out   (back_cmd),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    // Back: profile memory and update
    ppf_back #(
        .BINS (BINS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .alpha_q16  (alpha_q16),
        .cmd        (back_cmd),
        .cmd_valid  (queue_not_empty),
        .pop        (pop),
        .clear_busy (clear_busy),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule
